// ===== sv/ffa_pkg.sv =====
package ffa_pkg;

   // Default table depth
   localparam int NUM_FRAMES_DEFAULT = 4096;

   // Field widths
   localparam int OP_W     = 1;
   localparam int COUNT_W  = 13;
   localparam int FRAME_W  = 12;
   localparam int LIMIT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_USABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LIMIT  = 2'd1;

   // Register reset values
   localparam logic [FRAME_W-1:0] FIRST_USABLE_RESET = 12'd0;
   localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET  = 13'd4096;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_BAD_FRAME = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] page_count;
      logic [FRAME_W-1:0] frame_number;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  grant_frame;
   } rsp_payload_type;

   // One frame table entry
   typedef struct packed {
      logic cont;
      logic alloc;
   } mark_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

// ===== sv/first_fit_frame_allocator_unit.sv =====
// Channel   Ports                                   Transaction
// -------   -------------------------------------   ---------------------------------
// request   start, busy, req_payload                start high while busy low
// result    rsp_strobe, rsp_payload                 one cycle with rsp_strobe high
// config    csr_valid, csr_ready, csr_index/data    csr_valid and csr_ready both high
//
// Allocate: scan the frames from first_usable_frame up to min(frame_limit,
// NUM_FRAMES) for a free run of page_count frames, then mark the run, then
// give the result. Free: read and clear the table entries along the chain, then
// give the result. A rejected request goes from the accept cycle to the result cycle.
// After reset a clearing pass writes every entry, with busy high.
// A new request may be taken in the result cycle; the receiver cannot stall.
module first_fit_frame_allocator_unit #(
   parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ffa_pkg::req_payload_type            req_payload,
   output logic                                rsp_strobe,
   output ffa_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ffa_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ffa_pkg::*;

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int FC_W  = $clog2(NUM_FRAMES + 1);
   localparam int SUM_W = $clog2(NUM_FRAMES + 8192);

   state_type state_ff, state_in;

   logic [FRAME_W-1:0] first_usable_ff;
   logic [LIMIT_W-1:0] frame_limit_ff;
   logic [IDX_W-1:0]   clr_ff, clr_in;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [COUNT_W-1:0] run_ff, run_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [FC_W-1:0]    base_ff, base_in;
   logic [FC_W-1:0]    p_ff, p_in;
   logic [FC_W-1:0]    i_ff, i_in;
   logic               head_ff, head_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FRAME_W-1:0]  first_ff, first_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   mark_type         wr_mark;
   logic [IDX_W-1:0] rd_addr;
   mark_type         rd_mark;

   logic [FC_W-1:0]  lim;
   logic             accept;
   logic             alloc_reject;
   logic             free_reject;
   logic [SUM_W-1:0] end_sum;
   logic             scan_hit;
   logic             scan_fail;
   logic             walk_more;
   logic             mark_last;

   ffa_frame_table #(
      .NUM_FRAMES(NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_mark (wr_mark),
      .rd_addr (rd_addr),
      .rd_mark (rd_mark)
   );

   // Clamp the limit to the table depth
   always_comb begin
      if (SUM_W'(frame_limit_ff) > SUM_W'(NUM_FRAMES)) begin
         lim = FC_W'(NUM_FRAMES);
      end else begin
         lim = FC_W'(frame_limit_ff);
      end
   end

   // Take a request only while idle or presenting a result
   assign busy = (state_ff != ST_IDLE) && (state_ff != ST_RESP);

   // Decisions for the sequencer, some shared with the datapath
   assign accept       = start && !busy;
   assign alloc_reject = (req_payload.page_count == '0) ||
                         (SUM_W'(first_usable_ff) >= SUM_W'(lim));
   assign free_reject  = (SUM_W'(req_payload.frame_number) < SUM_W'(first_usable_ff)) ||
                         (SUM_W'(req_payload.frame_number) >= SUM_W'(lim));
   assign end_sum      = SUM_W'(base_ff) + SUM_W'(n_ff);
   assign scan_hit     = (run_ff == n_ff);
   assign scan_fail    = (end_sum > SUM_W'(lim));
   assign walk_more    = rd_mark.alloc && rd_mark.cont &&
                         ((SUM_W'(i_ff) + SUM_W'(1)) < SUM_W'(NUM_FRAMES));
   assign mark_last    = (left_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               if (req_payload.op == OP_ALLOC) begin
                  state_in = alloc_reject ? ST_RESP : ST_SCAN;
               end else begin
                  state_in = free_reject ? ST_RESP : ST_WALK;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_MARK;
            end else if (scan_fail) begin
               state_in = ST_RESP;
            end
         end
         ST_MARK: begin
            if (mark_last) begin
               state_in = ST_RESP;
            end
         end
         ST_WALK: begin
            if (!walk_more) begin
               state_in = ST_RESP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and table port control
   always_comb begin
      clr_in    = clr_ff;
      op_in     = op_ff;
      n_in      = n_ff;
      run_in    = run_ff;
      left_in   = left_ff;
      base_in   = base_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      head_in   = head_ff;
      status_in = status_ff;
      first_in  = first_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_mark   = '0;
      rd_addr   = IDX_W'(p_ff + FC_W'(1));
      case (state_ff)
         ST_CLEAR: begin
            // Sweep the table to all free
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
         end
         ST_IDLE, ST_RESP: begin
            // Fetch the first entry this transaction needs
            if (req_payload.op == OP_FREE) begin
               rd_addr = IDX_W'(req_payload.frame_number);
            end else begin
               rd_addr = IDX_W'(first_usable_ff);
            end
            if (accept) begin
               op_in    = req_payload.op;
               n_in     = req_payload.page_count;
               run_in   = '0;
               base_in  = FC_W'(first_usable_ff);
               p_in     = FC_W'(first_usable_ff);
               i_in     = FC_W'(req_payload.frame_number);
               head_in  = 1'b1;
               first_in = '0;
               if (req_payload.op == OP_ALLOC) begin
                  status_in = STATUS_NO_SPACE;
               end else begin
                  status_in = STATUS_BAD_FRAME;
               end
            end
         end
         ST_SCAN: begin
            // Examine the entry at p, restart past an allocated one
            if (scan_hit) begin
               wr_addr = IDX_W'(base_ff);
               p_in    = base_ff;
               left_in = n_ff - COUNT_W'(1);
            end else if (!scan_fail) begin
               p_in = p_ff + FC_W'(1);
               if (rd_mark.alloc) begin
                  base_in = p_ff + FC_W'(1);
                  run_in  = '0;
               end else begin
                  run_in = run_ff + COUNT_W'(1);
               end
            end
         end
         ST_MARK: begin
            // Mark the run, chaining all but the last frame
            wr_en         = 1'b1;
            wr_addr       = IDX_W'(p_ff);
            wr_mark.alloc = 1'b1;
            wr_mark.cont  = !mark_last;
            p_in          = p_ff + FC_W'(1);
            left_in       = left_ff - COUNT_W'(1);
            if (mark_last) begin
               status_in = STATUS_OK;
               first_in  = FRAME_W'(base_ff);
            end
         end
         ST_WALK: begin
            // Clear the chain, reading the next entry ahead
            rd_addr = IDX_W'(i_ff + FC_W'(1));
            if (rd_mark.alloc) begin
               wr_en     = 1'b1;
               wr_addr   = IDX_W'(i_ff);
               status_in = STATUS_OK;
               i_in      = i_ff + FC_W'(1);
               head_in   = 1'b0;
            end else if (!head_ff) begin
               status_in = STATUS_OK;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe              = (state_ff == ST_RESP);
   assign rsp_payload.status      = status_ff;
   assign rsp_payload.grant_frame = first_ff;
   assign csr_ready               = 1'b1;

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         first_usable_ff <= FIRST_USABLE_RESET;
         frame_limit_ff  <= FRAME_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_USABLE: first_usable_ff <= csr_data[FRAME_W-1:0];
               CSR_FRAME_LIMIT:  frame_limit_ff  <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      n_ff      <= n_in;
      run_ff    <= run_in;
      left_ff   <= left_in;
      base_ff   <= base_in;
      p_ff      <= p_in;
      i_ff      <= i_in;
      head_ff   <= head_in;
      status_ff <= status_in;
      first_ff  <= first_in;
   end

   // A scan never counts past the requested length
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (run_ff <= n_ff))
      else $error("scan run exceeds request length");

   // A run that gets marked lies inside the managed range
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (end_sum <= SUM_W'(lim)))
      else $error("marked run passes the frame limit");

   // A granted run starts at or above the first usable frame
   a_grant_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (op_ff == OP_ALLOC) && (status_ff == STATUS_OK)) |->
      (rsp_payload.grant_frame >= first_usable_ff))
      else $error("granted run below first usable frame");

   // Free results carry no frame number
   a_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (op_ff == OP_FREE)) |-> (rsp_payload.grant_frame == '0))
      else $error("free result with nonzero frame");

   // A result never comes straight out of the clearing pass
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) != ST_CLEAR))
      else $error("result strobe during clearing pass");

endmodule

// ===== sv/ffa_frame_table.sv =====
module ffa_frame_table #(
   parameter int NUM_FRAMES = ffa_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(NUM_FRAMES)-1:0] wr_addr,
   input  ffa_pkg::mark_type             wr_mark,
   input  logic [$clog2(NUM_FRAMES)-1:0] rd_addr,
   output ffa_pkg::mark_type             rd_mark
);
   import ffa_pkg::*;

   mark_type mem [NUM_FRAMES];
   mark_type rd_mark_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_mark;
      end
      rd_mark_ff <= mem[rd_addr];
   end

   assign rd_mark = rd_mark_ff;

endmodule
